/* hw/rtl/nrmc_pkg.sv */
// shared constants, types and character helpers of the rmc sentence parser
package nrmc_pkg;

  localparam int SENTENCE_BYTES = 128;
  localparam int ADDR_W = $clog2(SENTENCE_BYTES);
  localparam int CNT_W = $clog2(SENTENCE_BYTES + 1);

  localparam logic [1:0] ST_FIX   = 2'd0;
  localparam logic [1:0] ST_CSUM  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_OTHER = 2'd3;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  // ram write port driven by the front end
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  // completed sentence handed to the back end
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] len;
  } done_t;

  // running state of one coordinate field
  typedef struct packed {
    logic       active;
    logic       dot;
    logic [2:0] pre;
    logic [1:0] aft;
    logic [7:0] deg;
    logic [3:0] m1;
    logic [3:0] m2;
    logic [3:0] f0;
    logic [3:0] f1;
    logic [3:0] f2;
  } coord_t;

  function automatic logic is_valid_char(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DOLLAR || c == CH_COMMA ||
           c == CH_DOT || c == CH_MINUS || c == CH_SLASH || c == CH_STAR ||
           c == CH_CR || c == CH_LF;
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - 8'h30;
    return (c >= 8'h30 && c <= 8'h39) ? d[3:0] : 4'd0;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_of(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      d = c - 8'h57;
    end
    return d[3:0];
  endfunction

  // one character of a coordinate field; start opens the field with c
  function automatic coord_t coord_step(input coord_t s, input logic start,
                                        input logic [7:0] c);
    coord_t n;
    n = s;
    if (start) begin
      n = '0;
      n.active = 1'b1;
    end
    if (n.active) begin
      if (c == CH_COMMA) begin
        n.active = 1'b0;
      end else if (!n.dot) begin
        if (c == CH_DOT) begin
          n.dot = 1'b1;
        end else begin
          n.deg = 8'(n.deg * 8'd10) + {4'd0, n.m1};
          n.m1 = n.m2;
          n.m2 = digit_of(c);
          if (n.pre != 3'd4) n.pre = n.pre + 3'd1;
        end
      end else begin
        if (n.aft == 2'd0) n.f0 = digit_of(c);
        if (n.aft == 2'd1) n.f1 = digit_of(c);
        if (n.aft == 2'd2) n.f2 = digit_of(c);
        if (n.aft != 2'd3) n.aft = n.aft + 2'd1;
      end
    end
    return n;
  endfunction

  function automatic logic coord_ok(input coord_t s);
    return s.dot && s.pre == 3'd4 && s.aft != 2'd0;
  endfunction

  function automatic logic [30:0] coord_mm(input coord_t s);
    logic [31:0] v;
    v = 32'(s.m1) * 32'd10000 + 32'(s.m2) * 32'd1000 + 32'(s.f0) * 32'd100 +
        32'(s.f1) * 32'd10 + 32'(s.f2) + 32'(s.deg) * 32'd60000;
    return v[30:0];
  endfunction

endpackage

/* hw/rtl/nrmc_if.sv */
// valid/ready channels for received bytes and parse results
interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrmc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  sentence_status;
  logic [31:0] latitude_code;
  logic [31:0] longitude_code;
  modport source (output valid, output sentence_status, output latitude_code,
                  output longitude_code, input ready);
  modport sink (input valid, input sentence_status, input latitude_code,
                input longitude_code, output ready);
endinterface

/* hw/rtl/nmea_rmc_position_parser.sv */
// top level of the nmea rmc position parser
// Takes one received gps character per word on uart and reports one result word per
// completed sentence on result. Bytes are accepted one per cycle while no sentence is
// being evaluated; the line feed that closes a sentence hands its length to the back
// end, which walks the stored characters one per cycle through the store's single
// registered read port, so the input stalls while the sentence is walked and then
// until the result word is taken. Status is 0 for a valid rmc fix, 1 for a bad
// checksum, 2 for a malformed or void rmc sentence, 3 for any other sentence;
// positions are milliminutes with bit 31 marking south or west and are zero unless
// the status is 0.
module nmea_rmc_position_parser import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  nrmc_in_if.sink    uart,
  nrmc_out_if.source result
);
  ram_wr_t           wr;
  done_t             done, head;
  logic              pop, back_idle;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        rdata;

  // the store is shared, so bytes wait while a sentence is evaluated
  assign uart.ready = back_idle && !head.valid;

  // framing and store writes
  nrmc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (uart.valid && uart.ready),
    .rx_byte (uart.rx_byte),
    .wr      (wr),
    .done    (done)
  );

  // sentence character store
  nrmc_ram #(.WIDTH(8), .DEPTH(SENTENCE_BYTES)) u_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  // completed sentence hand-off
  nrmc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (done),
    .pop  (pop),
    .head (head)
  );

  // checksum, id and coordinate decode
  nrmc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .idle   (back_idle),
    .raddr  (raddr),
    .rdata  (rdata),
    .result (result)
  );
endmodule

/* hw/rtl/nrmc_ram.sv */
// generic single write port ram with registered read
module nrmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/nrmc_front.sv */
// front end: sentence framing, character screening and store writes
module nrmc_front import nrmc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output ram_wr_t    wr,
  output done_t      done
);
  logic             in_sentence;
  logic [CNT_W-1:0] char_count;

  always_comb begin
    wr.we   = 1'b0;
    wr.addr = char_count[ADDR_W-1:0];
    wr.data = rx_byte;
    done.valid = 1'b0;
    done.len   = char_count + CNT_W'(1);
    if (accept) begin
      if (!in_sentence) begin
        wr.we   = (rx_byte == CH_DOLLAR);
        wr.addr = '0;
      end else if (is_valid_char(rx_byte) && char_count < CNT_W'(SENTENCE_BYTES)) begin
        wr.we      = 1'b1;
        done.valid = (rx_byte == CH_LF);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      char_count  <= '0;
    end else if (accept) begin
      if (!in_sentence) begin
        if (rx_byte == CH_DOLLAR) begin
          in_sentence <= 1'b1;
          char_count  <= CNT_W'(1);
        end
      end else if (!wr.we || done.valid) begin
        in_sentence <= 1'b0;
        char_count  <= '0;
      end else begin
        char_count <= char_count + CNT_W'(1);
      end
    end
  end
endmodule

/* hw/rtl/nrmc_queue.sv */
// one-entry queue of completed sentence lengths
module nrmc_queue import nrmc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  done_t push,
  input  logic  pop,
  output done_t head
);
  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (push.valid) begin
      head.valid <= 1'b1;
    end else if (pop) begin
      head.valid <= 1'b0;
    end
    if (push.valid) head.len <= push.len;
  end
endmodule

/* hw/rtl/nrmc_back.sv */
// back end: walks a stored sentence, checks it and decodes the position
module nrmc_back import nrmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  done_t             head,
  output logic              pop,
  output logic              idle,
  output logic [ADDR_W-1:0] raddr,
  input  logic [7:0]        rdata,
  nrmc_out_if.source        result
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] len, rd_pos, dpos;
  logic             dvld;
  logic [7:0]       sum, hi, lo;
  logic             star_seen, id_ok, prev_delim, status_ok, lat_s, lon_w;
  logic [1:0]       aft_star;
  logic [3:0]       dcnt;
  coord_t           lat_c, lon_c;
  logic [1:0]       o_status;
  logic [31:0]      o_lat, o_lon;
  logic             is_delim, csum_ok, type_ok, fix;

  assign idle  = (state == S_IDLE);
  assign pop   = idle && head.valid;
  assign raddr = rd_pos[ADDR_W-1:0];
  assign is_delim = (rdata == CH_COMMA) || (rdata == CH_STAR);

  assign csum_ok = star_seen && aft_star == 2'd2 && is_hex(hi) && is_hex(lo) &&
                   {hex_of(hi), hex_of(lo)} == sum;
  assign type_ok = id_ok && len >= CNT_W'(6);
  assign fix = dcnt >= 4'd12 && status_ok && coord_ok(lat_c) && coord_ok(lon_c);

  assign result.valid           = (state == S_OUT);
  assign result.sentence_status = o_status;
  assign result.latitude_code   = o_lat;
  assign result.longitude_code  = o_lon;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dvld  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            state <= S_WALK;
            dvld  <= 1'b0;
          end
        end
        S_WALK: begin
          dvld <= (rd_pos < len);
          if (rd_pos >= len && !dvld) state <= S_CALC;
        end
        S_CALC: state <= S_OUT;
        S_OUT: begin
          if (result.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      len        <= head.len;
      rd_pos     <= CNT_W'(1);
      sum        <= '0;
      star_seen  <= 1'b0;
      aft_star   <= '0;
      id_ok      <= 1'b1;
      dcnt       <= '0;
      prev_delim <= 1'b0;
      status_ok  <= 1'b0;
      lat_s      <= 1'b0;
      lon_w      <= 1'b0;
      lat_c      <= '0;
      lon_c      <= '0;
    end
    if (state == S_WALK) begin
      if (rd_pos < len) begin
        rd_pos <= rd_pos + CNT_W'(1);
        dpos   <= rd_pos;
      end
      if (dvld) begin
        // checksum runs up to the first star, then grabs the hex pair
        if (!star_seen) begin
          if (rdata == CH_STAR) star_seen <= 1'b1;
          else sum <= sum ^ rdata;
        end else if (aft_star != 2'd2) begin
          if (aft_star == 2'd0) hi <= rdata;
          else lo <= rdata;
          aft_star <= aft_star + 2'd1;
        end
        // sentence id
        priority if (dpos == CNT_W'(1)) begin
          id_ok <= id_ok && rdata == CH_G;
        end else if (dpos == CNT_W'(2)) begin
          id_ok <= id_ok && (rdata == CH_P || rdata == CH_N);
        end else if (dpos == CNT_W'(3)) begin
          id_ok <= id_ok && rdata == CH_R;
        end else if (dpos == CNT_W'(4)) begin
          id_ok <= id_ok && rdata == CH_M;
        end else if (dpos == CNT_W'(5)) begin
          id_ok <= id_ok && rdata == CH_C;
        end else begin
          id_ok <= id_ok;
        end
        // field starts
        if (prev_delim && dcnt == 4'd2) status_ok <= (rdata == CH_A);
        if (prev_delim && dcnt == 4'd4 && rdata == CH_S) lat_s <= 1'b1;
        if (prev_delim && dcnt == 4'd6 && rdata == CH_W) lon_w <= 1'b1;
        lat_c <= coord_step(lat_c, prev_delim && dcnt == 4'd3, rdata);
        lon_c <= coord_step(lon_c, prev_delim && dcnt == 4'd5, rdata);
        prev_delim <= is_delim;
        if (is_delim && dcnt != 4'd12) dcnt <= dcnt + 4'd1;
      end
    end
    if (state == S_CALC) begin
      o_lat <= '0;
      o_lon <= '0;
      priority if (!csum_ok) begin
        o_status <= ST_CSUM;
      end else if (!type_ok) begin
        o_status <= ST_OTHER;
      end else if (fix) begin
        o_status <= ST_FIX;
        o_lat    <= {lat_s, coord_mm(lat_c)};
        o_lon    <= {lon_w, coord_mm(lon_c)};
      end else begin
        o_status <= ST_BAD;
      end
    end
  end
endmodule

/* hw/rtl/nrmc_checker.sv */
// port-level checks of the parser, bound to the top level
module nrmc_checker import nrmc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] lat,
  input logic [31:0] lon
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(lat) && $stable(lon))
    else $error("result word changed while stalled");

  a_zero_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FIX |-> lat == 32'd0 && lon == 32'd0)
    else $error("position reported without a fix");

  a_no_input_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");
endmodule

bind nmea_rmc_position_parser nrmc_checker u_nrmc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (uart.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .status    (result.sentence_status),
  .lat       (result.latitude_code),
  .lon       (result.longitude_code)
);

/* test/tb_nrmc_if.sv */
// testbench-side types of the rmc parser testbench
package tb_nrmc_pkg;

  // one parse result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] lat;
    logic [31:0] lon;
  } fix_t;

endpackage

/* test/tb_nmea_rmc_position_parser.sv */
// testbench of the nmea rmc position parser: directed sentences then random traffic
module tb_nmea_rmc_position_parser;
  import nrmc_pkg::*;
  import tb_nrmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  nrmc_in_if  uart ();
  nrmc_out_if result ();

  nmea_rmc_position_parser i_dut (
    .clk    (clk),
    .rst    (rst),
    .uart   (uart.sink),
    .result (result.source)
  );

  // predictor state: a copy of the sentence store and the fill count
  logic       pr_active;
  logic [7:0] pr_store [SENTENCE_BYTES];
  int         pr_count;

  fix_t fix_queue [$];
  int   n_errors = 0;
  int   n_mismatch = 0;
  int   cycle = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   n_items = 0;

  // directed table: one string per row, with an optional typed result
  typedef struct {
    string text;
    bit    known;
    fix_t  want;
  } row_t;
  row_t rows [$];

  function automatic logic [7:0] pr_at(int p);
    return (p < SENTENCE_BYTES) ? pr_store[p] : 8'h00;
  endfunction

  function automatic logic legal_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == CH_DOLLAR || c == CH_COMMA || c == CH_DOT || c == CH_MINUS ||
           c == CH_SLASH || c == CH_STAR || c == CH_CR || c == CH_LF;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function automatic logic [31:0] dec_digit(logic [7:0] c);
    return (c >= "0" && c <= "9") ? 32'(c - "0") : 32'd0;
  endfunction

  // skip past the next delimiter; 0 if the sentence ends first
  function automatic bit skip_field(ref int p, input int stop);
    logic [7:0] c;
    while (p < stop) begin
      c = pr_at(p);
      p++;
      if (c == CH_COMMA || c == CH_STAR) return 1'b1;
    end
    return 1'b0;
  endfunction

  // one coordinate field to milliminutes
  function automatic bit field_to_mm(int p, int stop, output logic [31:0] v);
    int len, dot, i;
    logic [31:0] place;
    logic [7:0]  deg;
    len = 0; dot = 0; place = 100; deg = 0; v = 0;
    while (p + len < stop && pr_at(p + len) != CH_COMMA) len++;
    while (dot < len && pr_at(p + dot) != CH_DOT) dot++;
    if (dot < 4 || len < dot + 2) return 1'b0;
    v = 10000 * dec_digit(pr_at(p + dot - 2)) + 1000 * dec_digit(pr_at(p + dot - 1));
    for (i = 0; i < len - dot - 1 && i < 3; i++) begin
      v += place * dec_digit(pr_at(p + dot + 1 + i));
      place = place / 10;
    end
    for (i = 0; i + 2 < dot; i++) deg = 8'(deg * 10 + dec_digit(pr_at(p + i)));
    v += 32'(deg) * 60000;
    return 1'b1;
  endfunction

  function automatic logic [1:0] eval_rmc(int stop, output logic [31:0] lat,
                                          output logic [31:0] lon);
    int p, k;
    p = 1; lat = 0; lon = 0;
    if (!skip_field(p, stop)) return ST_BAD;
    if (!skip_field(p, stop)) return ST_BAD;
    if (p >= stop || pr_at(p) != CH_A) return ST_BAD;
    if (!skip_field(p, stop)) return ST_BAD;
    if (!field_to_mm(p, stop, lat)) return ST_BAD;
    if (!skip_field(p, stop)) return ST_BAD;
    if (p < stop && pr_at(p) == CH_S) lat[31] = 1'b1;
    if (!skip_field(p, stop)) return ST_BAD;
    if (!field_to_mm(p, stop, lon)) return ST_BAD;
    if (!skip_field(p, stop)) return ST_BAD;
    if (p < stop && pr_at(p) == CH_W) lon[31] = 1'b1;
    for (k = 0; k < 6; k++) if (!skip_field(p, stop)) return ST_BAD;
    return ST_FIX;
  endfunction

  function automatic fix_t eval_sentence();
    fix_t r;
    int stop, star, hi, lo, i;
    logic [7:0] sum;
    stop = pr_count; star = 1; sum = 0;
    r = '0;
    while (star < stop && pr_at(star) != CH_STAR) star++;
    if (star + 2 >= stop) begin
      r.status = ST_CSUM;
      return r;
    end
    hi = hex_val(pr_at(star + 1));
    lo = hex_val(pr_at(star + 2));
    for (i = 1; i < star; i++) sum ^= pr_at(i);
    if (hi < 0 || lo < 0 || hi * 16 + lo != sum) begin
      r.status = ST_CSUM;
      return r;
    end
    if (stop < 6 || pr_at(1) != CH_G || (pr_at(2) != CH_P && pr_at(2) != CH_N) ||
        pr_at(3) != CH_R || pr_at(4) != CH_M || pr_at(5) != CH_C) begin
      r.status = ST_OTHER;
      return r;
    end
    r.status = eval_rmc(stop, r.lat, r.lon);
    if (r.status != ST_FIX) begin
      r.lat = 0;
      r.lon = 0;
    end
    return r;
  endfunction

  // advance the predictor by one accepted byte; 1 when a result is due
  function automatic bit take_byte(logic [7:0] c, output fix_t r);
    r = '0;
    if (!pr_active) begin
      if (c == CH_DOLLAR) begin
        pr_store[0] = c;
        pr_count = 1;
        pr_active = 1'b1;
      end
      return 1'b0;
    end
    if (!legal_char(c) || pr_count >= SENTENCE_BYTES) begin
      pr_active = 1'b0;
      pr_count = 0;
      return 1'b0;
    end
    pr_store[pr_count] = c;
    pr_count++;
    if (c != CH_LF) return 1'b0;
    r = eval_sentence();
    pr_active = 1'b0;
    pr_count = 0;
    return 1'b1;
  endfunction

  // append "*hh" and CR LF so the checksum is right
  function automatic string seal(string body);
    logic [7:0] s;
    s = 0;
    for (int i = 1; i < body.len(); i++) s ^= body[i];
    return $sformatf("%s*%02X\r\n", body, s);
  endfunction

  // random coordinate text with the given degree width
  function automatic string rand_coord(int degs);
    string t;
    t = "";
    for (int i = 0; i < degs + 2; i++) t = {t, string'(8'("0" + $urandom_range(0, 9)))};
    t = {t, "."};
    for (int i = 0; i < $urandom_range(1, 5); i++)
      t = {t, string'(8'("0" + $urandom_range(0, 9)))};
    return t;
  endfunction

  function automatic string rand_rmc();
    string b;
    b = {"$G", ($urandom_range(0, 1) ? "P" : "N"), "RMC,123519,",
         ($urandom_range(0, 9) ? "A" : "V"), ",", rand_coord($urandom_range(0, 4)), ",",
         ($urandom_range(0, 1) ? "S" : "N"), ",", rand_coord($urandom_range(0, 4)), ",",
         ($urandom_range(0, 1) ? "W" : "E"), ",022.4,084.4,230394,003.1,W"};
    return b;
  endfunction

  // one input word, with sender idling; valid stays up after the word is taken
  task automatic send_byte(logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      uart.valid <= 1'b0;
      @(posedge clk);
    end
    uart.valid <= 1'b1;
    uart.rx_byte <= c;
    @(posedge clk);
    while (!uart.ready) @(posedge clk);
    n_items++;
  endtask

  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_byte(t[i]);
  endtask

  // predictor runs on the accepted words
  always @(posedge clk) begin
    fix_t r;
    if (!rst && uart.valid && uart.ready) begin
      if (take_byte(uart.rx_byte, r)) fix_queue.push_back(r);
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    fix_t got, want;
    if (!rst && result.valid && result.ready) begin
      got = '{result.sentence_status, result.latitude_code, result.longitude_code};
      if (fix_queue.size() == 0) begin
        n_errors++;
        if (n_mismatch++ < 10) $display("unexpected result %p", got);
      end else begin
        want = fix_queue.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_mismatch++ < 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_row(string t, bit k, fix_t w);
    row_t r;
    r.text = t; r.known = k; r.want = w;
    rows.push_back(r);
  endtask

  initial begin
    string t;
    fix_t none, csum, other;
    none = '0;
    csum = '{ST_CSUM, 32'd0, 32'd0};
    other = '{ST_OTHER, 32'd0, 32'd0};
    uart.valid = 1'b0;
    uart.rx_byte = 8'h00;
    pr_active = 1'b0;
    pr_count = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows: typed results where obvious, predictor for the rest
    add_row(seal("$GPGGA,1,2"), 1, other);
    add_row("$GPRMC,1,A*ZZ\r\n", 1, csum);
    add_row("$GPRMC,1,A\r\n", 1, csum);
    add_row("$GPRMC*0\n", 1, csum);
    add_row("$GPRMC*00\n", 1, csum);
    add_row(seal("$GPRMC,1,V,4807.038,N,01131.000,E,,,,,"), 1, '{ST_BAD, 32'd0, 32'd0});
    add_row(seal("$GPRMC,1,A,4807.038,N,01131.000,E,,,,,"), 0, none);
    add_row(seal("$GNRMC,1,A,9959.999,S,25559.999,W,,,,,"), 0, none);
    add_row(seal("$GPRMC,1,A,99999.9,S,x2a4.12345,W,,,,,"), 0, none);
    add_row(seal("$GPRMC,1,A,807.0,N,1131.0,E,,,,,"), 0, none);
    add_row(seal("$GPRMC,1,A,4807.,N,01131.0,E,,,,,"), 0, none);
    add_row(seal("$GPRMC,1,A,4807.0,N,01131.0,E,,,"), 0, none);
    add_row("$GPRMC,1,A,48\x01\n", 0, none);
    add_row("zz\xff\x00$ab*cd\n", 0, none);
    t = "$";
    for (int i = 0; i < SENTENCE_BYTES; i++) t = {t, "a"};
    add_row(t, 0, none);
    add_row({"\n", seal("$gprmc,-/.A")}, 0, none);
    send_idle_pct = 24; recv_idle_pct = 70;
    foreach (rows[i]) begin
      send_text(rows[i].text);
      if (rows[i].known) begin
        // let the predictor queue it, then check the typed value against it
        uart.valid <= 1'b0;
        @(negedge clk);
        if (fix_queue.size() == 0) begin
          n_errors++;
          if (n_mismatch++ < 10) $display("row %0d: expected %p got none", i, rows[i].want);
        end else if (fix_queue[$] !== rows[i].want) begin
          n_errors++;
          if (n_mismatch++ < 10)
            $display("row %0d: expected %p got %p", i, rows[i].want, fix_queue[$]);
        end
        @(posedge clk);
      end
    end
    uart.valid <= 1'b0;

    // hold off until all expected words are back
    while (fix_queue.size() != 0) @(posedge clk);

    // random traffic in three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 24 : 0;
      while (n_items < 950 + ph * 450) begin
        case ($urandom_range(0, 9))
          0: t = {rand_rmc(), "\r\n"};
          1: begin
            t = "";
            for (int i = 0; i < $urandom_range(1, 30); i++) t = {t, string'(8'($urandom))};
          end
          2: t = seal("$GPGSV,3,1,11");
          3: begin
            t = seal(rand_rmc());
            t[$urandom_range(1, t.len() - 3)] = 8'($urandom);
          end
          default: t = seal(rand_rmc());
        endcase
        send_text(t);
      end
    end
    uart.valid <= 1'b0;

    while (fix_queue.size() != 0) @(posedge clk);
    repeat (SENTENCE_BYTES + 20) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
